// ===== sv/tti_pkg.sv =====
// ----------------------------------------------------------------------------
// tti_pkg: thermistor table interpolator shared definitions
// Table constants, field widths and the opcode type used by the block.
// ----------------------------------------------------------------------------
package tti_pkg;

  localparam int TABLE_ENTRIES = 33;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int VAL_W         = 32;
  localparam int RES_W         = 19;
  // widest span between two neighboring entries is 13200, so 14 bits hold it
  localparam int SPAN_W        = 14;
  // interpolated offset stays below the output span
  localparam int QUO_W         = SPAN_W;

  typedef logic signed [RES_W-1:0] ent_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [SPAN_W-1:0]       span_t;

  typedef enum logic {
    OP_CODE_TO_TEMP = 1'b0,
    OP_TEMP_TO_CODE = 1'b1
  } op_t;

  // adc codes, strictly descending
  localparam ent_t ROM_CODE [TABLE_ENTRIES] = '{
    19'sh00F8D, 19'sh00F6A, 19'sh00F29, 19'sh00EE4, 19'sh00E9D, 19'sh00E3F,
    19'sh00DBF, 19'sh00D33, 19'sh00C97, 19'sh00BF5, 19'sh00B3A, 19'sh00A42,
    19'sh007F1, 19'sh00734, 19'sh0066B, 19'sh005A3, 19'sh004EE, 19'sh00446,
    19'sh0043A, 19'sh00430, 19'sh003C3, 19'sh003BD, 19'sh0033B, 19'sh002BB,
    19'sh00259, 19'sh00206, 19'sh001CE, 19'sh00191, 19'sh00160, 19'sh0012E,
    19'sh000F9, 19'sh000D7, 19'sh0009F
  };

  // temperatures in millidegrees, strictly ascending
  localparam ent_t ROM_TEMP [TABLE_ENTRIES] = '{
    -19'sd26428, -19'sd21922, -19'sd15958, -19'sd11060, -19'sd6890,
    -19'sd2264,  19'sd2961,   19'sd7818,   19'sd12525,  19'sd16945,
    19'sd21623,  19'sd27431,  19'sd40631,  19'sd44960,  19'sd49757,
    19'sd54854,  19'sd59898,  19'sd65076,  19'sd65779,  19'sd65856,
    19'sd69654,  19'sd69873,  19'sd74910,  19'sd80691,  19'sd85844,
    19'sd90915,  19'sd94873,  19'sd99720,  19'sd104216, 19'sd109531,
    19'sd116445, 19'sd121600, 19'sd131839
  };

  // search key: the quantity the input is given in
  function automatic ent_t key_at(input op_t op, input idx_t idx);
    return (op == OP_TEMP_TO_CODE) ? ROM_TEMP[idx] : ROM_CODE[idx];
  endfunction

  // paired value: the quantity the result is given in
  function automatic ent_t val_at(input op_t op, input idx_t idx);
    return (op == OP_TEMP_TO_CODE) ? ROM_CODE[idx] : ROM_TEMP[idx];
  endfunction

  function automatic span_t span_abs(input logic signed [VAL_W:0] a);
    logic signed [VAL_W:0] m;
    m = (a < 0) ? -a : a;
    return m[SPAN_W-1:0];
  endfunction

endpackage

// ===== sv/tti_div.sv =====
// ----------------------------------------------------------------------------
// tti_div: restoring divider, one quotient bit per cycle
// Divides num by den where num >> QUO_W is already below den.
// ----------------------------------------------------------------------------
module tti_div #(
  parameter int DEN_W = tti_pkg::SPAN_W,
  parameter int QUO_W = tti_pkg::QUO_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DEN_W+QUO_W-1:0] num,
  input  logic [DEN_W-1:0]       den,
  output logic                   done,
  output logic [QUO_W-1:0]       quo
);
  import tti_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] num_r;
  logic [QUO_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             qbit;

  assign trial = {rem_r, num_r[QUO_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign qbit  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= num[DEN_W+QUO_W-1:QUO_W];
        num_r <= num[QUO_W-1:0];
        den_r <= den;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_r <= {num_r[QUO_W-2:0], 1'b0};
        quo_r <= {quo_r[QUO_W-2:0], qbit};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held longer than one cycle");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> run_r)
    else $error("divider did not start");

endmodule

// ===== sv/thermistor_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// thermistor_table_interpolator: adc code <-> temperature conversion
// Piecewise linear lookup in a fixed table of (code, temperature) pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_opcode (0 = adc code to millidegrees, 1 = millidegrees to
//   adc code) and in_value, and raise start. The transfer happens at a clock
//   edge with start high and busy low. busy then stays high until the result
//   has been produced; no new item is taken meanwhile.
//   Output: out_result is valid for exactly one cycle, marked by out_valid.
//   The receiver cannot stall, so the result is taken in that cycle.
// Sequence: one shared comparator steps through the clamp checks against both
// ends of the table and a five-step bisection of the table; an input that
// clamps finishes at a clamp check, an exact table hit finishes after the
// bisection, and an interpolated input goes on to one multiply and a 14-step
// restoring divide for the interpolated offset. A new item can be started the
// cycle out_valid is high.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid; an item in flight is discarded.
// ----------------------------------------------------------------------------
module thermistor_table_interpolator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_opcode,
  input  logic signed [tti_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  output logic signed [tti_pkg::RES_W-1:0]  out_result
);
  import tti_pkg::*;

  localparam idx_t LAST = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP_LO,
    ST_CLAMP_HI,
    ST_SEARCH,
    ST_EXACT,
    ST_SPAN,
    ST_MUL,
    ST_DIV
  } state_t;

  state_t                    state_r;
  op_t                       op_r;
  logic signed [VAL_W-1:0]   v_r;
  idx_t                      lo_r;
  idx_t                      hi_r;
  span_t                     x_r;
  span_t                     n_r;
  span_t                     d_r;
  ent_t                      base_r;
  ent_t                      result_r;
  logic                      out_valid_r;

  // shared comparator
  logic [IDX_W:0]            mid_sum;
  idx_t                      mid;
  idx_t                      cmp_idx;
  ent_t                      key_sel;
  ent_t                      val_sel;
  logic signed [VAL_W-1:0]   key_ext;
  logic                      key_lt;
  logic                      key_eq;
  logic                      beyond;
  idx_t                      lo_nxt;
  idx_t                      hi_nxt;

  // span computation
  ent_t                      key_lo;
  ent_t                      key_hi;
  ent_t                      val_lo;
  ent_t                      val_hi;
  logic signed [VAL_W:0]     x_diff;
  logic signed [VAL_W:0]     n_diff;
  logic signed [VAL_W:0]     d_diff;

  logic [2*SPAN_W-1:0]       mul_out;
  logic                      div_start;
  logic                      div_done;
  logic [QUO_W-1:0]          div_quo;
  ent_t                      quo_ext;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[IDX_W:1];

  always_comb begin
    unique case (state_r)
      ST_CLAMP_LO: cmp_idx = '0;
      ST_CLAMP_HI: cmp_idx = LAST;
      ST_SEARCH:   cmp_idx = mid;
      default:     cmp_idx = lo_r;
    endcase
  end

  assign key_sel = key_at(op_r, cmp_idx);
  assign val_sel = val_at(op_r, cmp_idx);
  assign key_ext = VAL_W'(key_sel);
  assign key_lt  = (key_ext < v_r);
  assign key_eq  = (key_ext == v_r);
  // this entry lies past the input in the table's direction
  assign beyond  = (op_r == OP_CODE_TO_TEMP) ? key_lt : (!key_lt && !key_eq);

  assign lo_nxt = beyond ? lo_r : mid;
  assign hi_nxt = beyond ? mid  : hi_r;

  assign key_lo = key_at(op_r, lo_r);
  assign key_hi = key_at(op_r, hi_r);
  assign val_lo = val_at(op_r, lo_r);
  assign val_hi = val_at(op_r, hi_r);
  assign x_diff = (VAL_W+1)'(val_lo) - (VAL_W+1)'(val_hi);
  assign n_diff = (VAL_W+1)'(v_r)    - (VAL_W+1)'(key_hi);
  assign d_diff = (VAL_W+1)'(key_lo) - (VAL_W+1)'(key_hi);

  assign mul_out   = x_r * n_r;
  assign div_start = (state_r == ST_MUL);
  assign quo_ext   = $signed(RES_W'(div_quo));

  tti_div #(
    .DEN_W (SPAN_W),
    .QUO_W (QUO_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mul_out),
    .den   (d_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            op_r    <= op_t'(in_opcode);
            v_r     <= in_value;
            lo_r    <= '0;
            hi_r    <= LAST;
            state_r <= ST_CLAMP_LO;
          end
        end
        ST_CLAMP_LO: begin
          if (beyond || key_eq) begin
            result_r    <= val_sel;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else begin
            state_r <= ST_CLAMP_HI;
          end
        end
        ST_CLAMP_HI: begin
          if (!beyond) begin
            result_r    <= val_sel;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else if (hi_r - lo_r > IDX_W'(1)) begin
            state_r <= ST_SEARCH;
          end else begin
            state_r <= ST_EXACT;
          end
        end
        ST_SEARCH: begin
          // bisect: lo stays at or short of the input, hi past it
          lo_r <= lo_nxt;
          hi_r <= hi_nxt;
          if (hi_nxt - lo_nxt == IDX_W'(1)) begin
            state_r <= ST_EXACT;
          end
        end
        ST_EXACT: begin
          if (key_eq) begin
            result_r    <= val_sel;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else begin
            state_r <= ST_SPAN;
          end
        end
        ST_SPAN: begin
          x_r     <= span_abs(x_diff);
          n_r     <= span_abs(n_diff);
          d_r     <= span_abs(d_diff);
          base_r  <= val_hi;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            // temperature falls toward the lower index, code rises
            result_r    <= (op_r == OP_CODE_TO_TEMP) ? base_r - quo_ext
                                                     : base_r + quo_ext;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = result_r;

  a_result_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("sequencer went idle without a result");

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer did not start the sequencer");

  a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (lo_r < hi_r))
    else $error("search bounds crossed");

endmodule

// ===== verif/thermistor_table_interpolator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_table_interpolator_tb: self-checking bench for the interpolator
// Drives adc codes and temperatures in bursts with random gaps, predicts every
// conversion from a private copy of the calibration table and checks each
// out_valid transfer against the oldest pending prediction.
// ----------------------------------------------------------------------------
module thermistor_table_interpolator_tb;

  localparam int ENTRIES    = 33;
  localparam int RES_W      = tti_pkg::RES_W;
  localparam int IDLE_LIMIT = 2000;
  localparam int ITEM_GOAL  = 900;
  localparam int DRAIN_WAIT = 40;

  // calibration pairs: codes descend, millidegrees ascend
  localparam longint CAL_CODE [ENTRIES] = '{
    'hF8D, 'hF6A, 'hF29, 'hEE4, 'hE9D, 'hE3F, 'hDBF, 'hD33, 'hC97, 'hBF5, 'hB3A,
    'hA42, 'h7F1, 'h734, 'h66B, 'h5A3, 'h4EE, 'h446, 'h43A, 'h430, 'h3C3, 'h3BD,
    'h33B, 'h2BB, 'h259, 'h206, 'h1CE, 'h191, 'h160, 'h12E, 'hF9,  'hD7,  'h9F
  };
  localparam longint CAL_TEMP [ENTRIES] = '{
    -26428, -21922, -15958, -11060, -6890, -2264, 2961, 7818, 12525, 16945,
    21623, 27431, 40631, 44960, 49757, 54854, 59898, 65076, 65779, 65856,
    69654, 69873, 74910, 80691, 85844, 90915, 94873, 99720, 104216, 109531,
    116445, 121600, 131839
  };

  typedef enum int {
    SEG_CLAMP  = 0,
    SEG_EXACT  = 1,
    SEG_INTERP = 2
  } seg_t;

  class conversion_scoreboard;
    logic [RES_W-1:0] expected_results[$];
    int errors;
    int checked;
    int by_op[2];
    int by_seg[3];

    function longint lerp_offset(longint x, longint n, longint d);
      if (d == 0) return 0;
      return (x / d) * n + ((x % d) * n) / d;
    endfunction

    // codes are negated so both key sets ascend; flipping the sign of both
    // n and d leaves the truncated lerp offset unchanged
    function longint convert_reading(tti_pkg::op_t op, longint v, output seg_t seg);
      longint key [ENTRIES];
      longint res [ENTRIES];
      longint w;
      int lo, hi, mid;
      for (int i = 0; i < ENTRIES; i++) begin
        key[i] = (op == tti_pkg::OP_TEMP_TO_CODE) ? CAL_TEMP[i] : -CAL_CODE[i];
        res[i] = (op == tti_pkg::OP_TEMP_TO_CODE) ? CAL_CODE[i] : CAL_TEMP[i];
      end
      w = (op == tti_pkg::OP_TEMP_TO_CODE) ? v : -v;
      seg = SEG_CLAMP;
      if (key[0] >= w) return res[0];
      if (key[ENTRIES-1] <= w) return res[ENTRIES-1];
      lo = 0;
      hi = ENTRIES - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (key[mid] < w) begin
          lo = mid + 1;
        end else if (key[mid] > w) begin
          hi = mid - 1;
        end else begin
          seg = SEG_EXACT;
          return res[mid];
        end
      end
      seg = SEG_INTERP;
      if (lo < 1 || lo > ENTRIES - 1) return 0;
      return res[lo] + lerp_offset(res[lo-1] - res[lo], w - key[lo], key[lo-1] - key[lo]);
    endfunction

    function void note_item(tti_pkg::op_t op, logic signed [31:0] value);
      seg_t seg;
      longint r;
      r = convert_reading(op, longint'(value), seg);
      expected_results.push_back(r[RES_W-1:0]);
      by_op[int'(op)]++;
      by_seg[int'(seg)]++;
    endfunction

    function void check_result(logic [RES_W-1:0] actual);
      logic [RES_W-1:0] want;
      if (expected_results.size() == 0) begin
        $error("out_result: no conversion pending, actual %0d", $signed(actual));
        errors++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (actual !== want) begin
        $error("out_result mismatch: expected %0d, actual %0d", $signed(want), $signed(actual));
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_opcode;
  logic signed [31:0]       in_value;
  logic                     out_valid;
  logic signed [RES_W-1:0]  out_result;

  conversion_scoreboard conv_sb;
  int idle_cycles;
  int items_sent;

  thermistor_table_interpolator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_opcode  (in_opcode),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n && start && !busy) conv_sb.note_item(tti_pkg::op_t'(in_opcode), in_value);
    if (rst_n && out_valid) conv_sb.check_result(out_result);
    if ((start && !busy) || out_valid) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("** thermistor_table_interpolator: FAILED **");
      $finish;
    end
  end

  // entered and left at a falling edge; start stays high for back-to-back items
  task automatic send_item(tti_pkg::op_t op, logic signed [31:0] value);
    bit taken;
    start     = 1'b1;
    in_opcode = op;
    in_value  = value;
    taken     = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = start && !busy;
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap(int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_value(tti_pkg::op_t op);
    int r;
    int idx;
    r   = $urandom_range(0, 99);
    idx = $urandom_range(0, ENTRIES - 1);
    if (r < 15) begin
      // land on a table entry or right next to it
      return 32'((op == tti_pkg::OP_TEMP_TO_CODE ? CAL_TEMP[idx] : CAL_CODE[idx])
             + int'($urandom_range(0, 2)) - 1);
    end else if (r < 75) begin
      if (op == tti_pkg::OP_TEMP_TO_CODE) return int'($urandom_range(0, 158267)) - 26428;
      return int'($urandom_range('h9F, 'hF8D));
    end else if (r < 88) begin
      if (op == tti_pkg::OP_TEMP_TO_CODE) return int'($urandom_range(0, 200000)) - 50000;
      return int'($urandom_range(0, 4095));
    end
    return $urandom;
  endfunction

  localparam int DIR_N = 24;
  localparam bit DIR_OP [DIR_N] = '{
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1
  };
  localparam int DIR_VAL [DIR_N] = '{
    0, 4095, 32'h8000_0000, 32'h7FFF_FFFF, 'hF8D, 'hF8C, 'h9F, 'hA0,
    'hA42, 'hA41, 'h7F2, 'h430,
    32'h8000_0000, 32'h7FFF_FFFF, -26428, -26427, 131839, 131838,
    27431, 27432, 65856, 0, 40630, -1
  };

  initial begin
    int burst;
    conv_sb     = new;
    idle_cycles = 0;
    items_sent  = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_opcode   = 1'b0;
    in_value    = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // ends of the table, exact hits, neighbors of entries, extreme values
    for (int i = 0; i < DIR_N; i++) begin
      send_item(DIR_OP[i] ? tti_pkg::OP_TEMP_TO_CODE : tti_pkg::OP_CODE_TO_TEMP, DIR_VAL[i]);
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 5));
    end

    while (items_sent < DIR_N + ITEM_GOAL) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst; i++) begin
        tti_pkg::op_t op;
        op = $urandom_range(0, 1) ? tti_pkg::OP_TEMP_TO_CODE : tti_pkg::OP_CODE_TO_TEMP;
        send_item(op, pick_value(op));
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 50));
    end
    start = 1'b0;

    while (conv_sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d conversions: %0d code->temp, %0d temp->code; %0d clamped, %0d exact, %0d interpolated",
             items_sent, conv_sb.by_op[0], conv_sb.by_op[1],
             conv_sb.by_seg[SEG_CLAMP], conv_sb.by_seg[SEG_EXACT], conv_sb.by_seg[SEG_INTERP]);
    $display("%0d results checked, %0d mismatches", conv_sb.checked, conv_sb.errors);
    if (conv_sb.errors == 0 && conv_sb.expected_results.size() == 0) begin
      $display("** thermistor_table_interpolator: PASSED **");
    end else begin
      $display("** thermistor_table_interpolator: FAILED **");
    end
    $finish;
  end

endmodule
